// ===== src/lp2c_pkg.sv =====
// ----------------------------------------------------------------------------
// lp2c_pkg
// shared types, constants and tables of the lidar polar to cartesian core
// ----------------------------------------------------------------------------
package lp2c_pkg;

    localparam int MAX_POINTS    = 4096;
    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 13;
    localparam int CNT_W         = 5;
    localparam int FULL_TURN     = 3600000;
    localparam int QUARTER_TURN  = 900000;
    localparam int GAIN_Q30      = 652032875;
    localparam int OUT_MAX       = 16777215;
    localparam int OUT_MIN       = -16777216;
    // two full turns less a quarter turn added so the angle sum never goes negative
    localparam int ANGLE_BIAS    = 2 * FULL_TURN - QUARTER_TURN;
    localparam int RED_STEPS     = 9;

    typedef enum logic [2:0] {
        CFG_FIRST_ANGLE    = 3'd0,
        CFG_STEP_ANGLE     = 3'd1,
        CFG_DISTANCE_SCALE = 3'd2,
        CFG_LAYER_COSINE   = 3'd3,
        CFG_LAYER_SINE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [22:0] first_angle;
        logic        [16:0] step_angle;
        logic        [15:0] distance_scale;
        logic signed [15:0] layer_cosine;
        logic signed [15:0] layer_sine;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  quad;
        logic [19:0] resid;
        logic [15:0] raw;
        logic [7:0]  inten;
        logic [2:0]  echo;
        logic        last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_RED,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_MUL1,
        B_MUL2,
        B_OUT
    } back_state_t;

    // arctangent of 2^-i in 1/2560000 degree
    function automatic logic signed [29:0] atan_val(input logic [CNT_W-1:0] i);
        logic signed [29:0] v;
        unique case (i)
            5'd0:    v = 30'sd115200000;
            5'd1:    v = 30'sd68006531;
            5'd2:    v = 30'sd35932783;
            5'd3:    v = 30'sd18240042;
            5'd4:    v = 30'sd9155416;
            5'd5:    v = 30'sd4582171;
            5'd6:    v = 30'sd2291645;
            5'd7:    v = 30'sd1145892;
            5'd8:    v = 30'sd572955;
            5'd9:    v = 30'sd286479;
            5'd10:   v = 30'sd143239;
            5'd11:   v = 30'sd71620;
            5'd12:   v = 30'sd35810;
            5'd13:   v = 30'sd17905;
            5'd14:   v = 30'sd8952;
            5'd15:   v = 30'sd4476;
            5'd16:   v = 30'sd2238;
            5'd17:   v = 30'sd1119;
            5'd18:   v = 30'sd560;
            5'd19:   v = 30'sd280;
            5'd20:   v = 30'sd140;
            5'd21:   v = 30'sd70;
            5'd22:   v = 30'sd35;
            5'd23:   v = 30'sd17;
            default: v = 30'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [24:0] sat25(input logic signed [31:0] v);
        logic signed [24:0] r;
        if (v > 32'sd16777215)
            r = 25'(OUT_MAX);
        else if (v < -32'sd16777216)
            r = 25'(OUT_MIN);
        else
            r = v[24:0];
        return r;
    endfunction

endpackage

// ===== src/lp2c_front.sv =====
// ----------------------------------------------------------------------------
// lp2c_front
// accepts samples, keeps the point index and reduces the beam angle to a
// quadrant and a rest within it
// ----------------------------------------------------------------------------
module lp2c_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         raw_distance,
    input  logic [7:0]          intensity_in,
    input  logic [2:0]          echo_number,
    input  logic                last_of_scan,
    input  lp2c_pkg::cfg_t      cfg,
    input  lp2c_pkg::fifo_stat_t q_stat,
    output logic                push,
    output lp2c_pkg::item_t     push_item
);

    lp2c_pkg::front_state_t state_reg, state_next;
    logic [lp2c_pkg::IDX_W-1:0] idx_reg, idx_snap_reg;
    logic [lp2c_pkg::IDX_W-1:0] idx_inc;
    logic [3:0]                 k_reg;
    logic [30:0]                acc_reg;
    logic [15:0]                raw_reg;
    logic [7:0]                 inten_reg;
    logic [2:0]                 echo_reg;
    logic                       last_reg;
    logic                       accept;
    logic [29:0]                prod;
    logic signed [31:0]         sum;
    logic [30:0]                thr;
    logic [1:0]                 quad;
    logic [21:0]                resid;

    assign accept  = in_valid && !in_stall;
    assign idx_inc = idx_reg + 1'b1;
    assign prod    = 30'(idx_snap_reg) * 30'(cfg.step_angle);
    assign sum     = 32'(cfg.first_angle) + $signed({2'b00, prod})
                     + 32'(lp2c_pkg::ANGLE_BIAS);
    assign thr     = 31'(lp2c_pkg::FULL_TURN) << k_reg;

    always_comb
    begin
        if (acc_reg >= 31'(3 * lp2c_pkg::QUARTER_TURN))
        begin
            quad  = 2'd3;
            resid = 22'(acc_reg - 31'(3 * lp2c_pkg::QUARTER_TURN));
        end
        else if (acc_reg >= 31'(2 * lp2c_pkg::QUARTER_TURN))
        begin
            quad  = 2'd2;
            resid = 22'(acc_reg - 31'(2 * lp2c_pkg::QUARTER_TURN));
        end
        else if (acc_reg >= 31'(lp2c_pkg::QUARTER_TURN))
        begin
            quad  = 2'd1;
            resid = 22'(acc_reg - 31'(lp2c_pkg::QUARTER_TURN));
        end
        else
        begin
            quad  = 2'd0;
            resid = acc_reg[21:0];
        end
    end

    always_comb
    begin
        push_item.quad  = quad;
        push_item.resid = resid[19:0];
        push_item.raw   = raw_reg;
        push_item.inten = inten_reg;
        push_item.echo  = echo_reg;
        push_item.last  = last_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lp2c_pkg::F_IDLE: if (in_valid) state_next = lp2c_pkg::F_MUL;
            lp2c_pkg::F_MUL:  state_next = lp2c_pkg::F_RED;
            lp2c_pkg::F_RED:  if (k_reg == 4'd0) state_next = lp2c_pkg::F_PUSH;
            lp2c_pkg::F_PUSH: if (!q_stat.full) state_next = lp2c_pkg::F_IDLE;
            default: state_next = lp2c_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != lp2c_pkg::F_IDLE);
        push     = (state_reg == lp2c_pkg::F_PUSH) && !q_stat.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lp2c_pkg::F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (last_of_scan || (32'(idx_inc) >= 32'(lp2c_pkg::MAX_POINTS)))
                    idx_reg <= '0;
                else
                    idx_reg <= idx_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_snap_reg <= idx_reg;
            raw_reg      <= raw_distance;
            inten_reg    <= intensity_in;
            echo_reg     <= echo_number;
            last_reg     <= last_of_scan;
        end
        if (state_reg == lp2c_pkg::F_MUL)
        begin
            acc_reg <= sum[30:0];
            k_reg   <= 4'(lp2c_pkg::RED_STEPS - 1);
        end
        else if (state_reg == lp2c_pkg::F_RED)
        begin
            // one compare and subtract of a shifted full turn a cycle
            if (acc_reg >= thr)
                acc_reg <= acc_reg - thr;
            k_reg <= k_reg - 1'b1;
        end
    end

endmodule

// ===== src/lp2c_fifo.sv =====
// ----------------------------------------------------------------------------
// lp2c_fifo
// two-entry queue of reduced angle words between front and back
// ----------------------------------------------------------------------------
module lp2c_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lp2c_pkg::item_t      push_item,
    input  logic                 pop,
    output lp2c_pkg::item_t      pop_item,
    output lp2c_pkg::fifo_stat_t q_stat
);

    lp2c_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/lp2c_back.sv =====
// ----------------------------------------------------------------------------
// lp2c_back
// iterative cordic rotation, scaling multiplies, rounding and saturation,
// and the output register
// ----------------------------------------------------------------------------
module lp2c_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lp2c_pkg::cfg_t       cfg,
    input  lp2c_pkg::fifo_stat_t q_stat,
    input  lp2c_pkg::item_t      pop_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [24:0]   x_pos,
    output logic signed [24:0]   y_pos,
    output logic signed [24:0]   z_pos,
    output logic [7:0]           intensity_out,
    output logic [2:0]           echo_tag,
    output logic                 scan_end
);

    lp2c_pkg::back_state_t state_reg, state_next;
    logic [lp2c_pkg::CNT_W-1:0] cnt_reg;
    logic signed [32:0]         x_reg, y_reg;
    logic signed [29:0]         z_reg;
    logic [1:0]                 quad_reg;
    logic [31:0]                dq_reg;
    logic [7:0]                 inten_reg;
    logic [2:0]                 echo_reg;
    logic                       last_reg;
    logic signed [65:0]         px_reg, py_reg;
    logic signed [48:0]         pz_reg;
    logic signed [51:0]         mx_reg, my_reg;
    logic signed [25:0]         rz_reg;
    logic signed [32:0]         dxs, dys, cm, sm, dqs;
    logic signed [29:0]         at;
    logic signed [65:0]         px_rnd, py_rnd;
    logic signed [35:0]         tx, ty;
    logic signed [48:0]         pz_rnd;
    logic signed [51:0]         mx_rnd, my_rnd;
    logic                       out_load;
    logic                       out_valid_reg;

    assign dxs    = y_reg >>> cnt_reg;
    assign dys    = x_reg >>> cnt_reg;
    assign at     = lp2c_pkg::atan_val(cnt_reg);
    assign dqs    = $signed({1'b0, dq_reg});
    assign px_rnd = (px_reg + (66'sd1 <<< 29)) >>> 30;
    assign py_rnd = (py_reg + (66'sd1 <<< 29)) >>> 30;
    assign tx     = px_rnd[35:0];
    assign ty     = py_rnd[35:0];
    assign pz_rnd = (pz_reg + (49'sd1 <<< 22)) >>> 23;
    assign mx_rnd = (mx_reg + (52'sd1 <<< 22)) >>> 23;
    assign my_rnd = (my_reg + (52'sd1 <<< 22)) >>> 23;
    assign out_valid = out_valid_reg;

    // quadrant fold of the rotated vector
    always_comb
    begin
        unique case (quad_reg)
            2'd0:    begin cm = x_reg;  sm = y_reg;  end
            2'd1:    begin cm = -y_reg; sm = x_reg;  end
            2'd2:    begin cm = -x_reg; sm = -y_reg; end
            default: begin cm = y_reg;  sm = -x_reg; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lp2c_pkg::B_IDLE: if (!q_stat.empty) state_next = lp2c_pkg::B_ROT;
            lp2c_pkg::B_ROT:
                if (cnt_reg == lp2c_pkg::CNT_W'(lp2c_pkg::CORDIC_STAGES - 1))
                    state_next = lp2c_pkg::B_MUL1;
            lp2c_pkg::B_MUL1: state_next = lp2c_pkg::B_MUL2;
            lp2c_pkg::B_MUL2: state_next = lp2c_pkg::B_OUT;
            lp2c_pkg::B_OUT:
                if (!out_valid_reg || !out_stall) state_next = lp2c_pkg::B_IDLE;
            default: state_next = lp2c_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == lp2c_pkg::B_IDLE) && !q_stat.empty;
        out_load = (state_reg == lp2c_pkg::B_OUT) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lp2c_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cnt_reg   <= '0;
            x_reg     <= 33'(lp2c_pkg::GAIN_Q30);
            y_reg     <= '0;
            z_reg     <= $signed({2'b00, pop_item.resid, 8'h00});
            quad_reg  <= pop_item.quad;
            dq_reg    <= 32'(pop_item.raw) * 32'(cfg.distance_scale);
            inten_reg <= pop_item.inten;
            echo_reg  <= pop_item.echo;
            last_reg  <= pop_item.last;
        end
        else if (state_reg == lp2c_pkg::B_ROT)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dxs;
                y_reg <= y_reg + dys;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dxs;
                y_reg <= y_reg - dys;
                z_reg <= z_reg + at;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == lp2c_pkg::B_MUL1)
        begin
            px_reg <= 66'(dqs) * 66'(cm);
            py_reg <= 66'(dqs) * 66'(sm);
            pz_reg <= 49'(dqs) * 49'(cfg.layer_sine);
        end
        if (state_reg == lp2c_pkg::B_MUL2)
        begin
            mx_reg <= 52'(tx) * 52'(cfg.layer_cosine);
            my_reg <= 52'(ty) * 52'(cfg.layer_cosine);
            rz_reg <= pz_rnd[25:0];
        end
        if (out_load)
        begin
            x_pos         <= lp2c_pkg::sat25($signed(mx_rnd[31:0]));
            y_pos         <= lp2c_pkg::sat25($signed(my_rnd[31:0]));
            z_pos         <= lp2c_pkg::sat25(32'(rz_reg));
            intensity_out <= inten_reg;
            echo_tag      <= echo_reg;
            scan_end      <= last_reg;
        end
    end

endmodule

// ===== src/lidar_polar_to_cartesian_core.sv =====
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_core
// converts laser range samples to saturated x, y, z coordinates
// ----------------------------------------------------------------------------
// the front reduces the angle of one word at a time (angle reduction, 9 steps),
//   the back rotates one word at a time (iterative rotation, CORDIC_STAGES steps,
//   16 stages); neither takes a new word before it is through with the last, and
//   the back sets the sustained rate
// reset: asynchronous, clears point index, queue and output valid, and loads
//   the register reset values
module lidar_polar_to_cartesian_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        raw_distance,
    input  logic [7:0]         intensity_in,
    input  logic [2:0]         echo_number,
    input  logic               last_of_scan,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [24:0] x_pos,
    output logic signed [24:0] y_pos,
    output logic signed [24:0] z_pos,
    output logic [7:0]         intensity_out,
    output logic [2:0]         echo_tag,
    output logic               scan_end
);

    lp2c_pkg::cfg_t       cfg_reg;
    lp2c_pkg::fifo_stat_t q_stat;
    lp2c_pkg::item_t      push_item, pop_item;
    logic                 push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_angle    <= -23'sd450000;
            cfg_reg.step_angle     <= 17'd5000;
            cfg_reg.distance_scale <= 16'd4096;
            cfg_reg.layer_cosine   <= 16'sd32767;
            cfg_reg.layer_sine     <= 16'sd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lp2c_pkg::CFG_FIRST_ANGLE:    cfg_reg.first_angle    <= cfg_data;
                lp2c_pkg::CFG_STEP_ANGLE:     cfg_reg.step_angle     <= cfg_data[16:0];
                lp2c_pkg::CFG_DISTANCE_SCALE: cfg_reg.distance_scale <= cfg_data[15:0];
                lp2c_pkg::CFG_LAYER_COSINE:   cfg_reg.layer_cosine   <= cfg_data[15:0];
                lp2c_pkg::CFG_LAYER_SINE:     cfg_reg.layer_sine     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    lp2c_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_distance (raw_distance),
        .intensity_in (intensity_in),
        .echo_number  (echo_number),
        .last_of_scan (last_of_scan),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_item    (push_item)
    );

    lp2c_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    lp2c_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_stat        (q_stat),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .z_pos         (z_pos),
        .intensity_out (intensity_out),
        .echo_tag      (echo_tag),
        .scan_end      (scan_end)
    );

endmodule

// ===== src/lp2c_checker.sv =====
// ----------------------------------------------------------------------------
// lp2c_checker
// port-level checks of the lidar polar to cartesian core
// ----------------------------------------------------------------------------
module lp2c_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_wr_en,
    input logic [2:0]         cfg_index,
    input logic [22:0]        cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic [15:0]        raw_distance,
    input logic [7:0]         intensity_in,
    input logic [2:0]         echo_number,
    input logic               last_of_scan,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [24:0] x_pos,
    input logic signed [24:0] y_pos,
    input logic signed [24:0] z_pos,
    input logic [7:0]         intensity_out,
    input logic [2:0]         echo_tag,
    input logic               scan_end
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(x_pos) && $stable(y_pos) && $stable(z_pos)
            && $stable(intensity_out) && $stable(echo_tag) && $stable(scan_end))
        else $error("stalled result word changed");

    // the front works one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("front took a second word while busy");

    // in reset nothing is offered and the input is open
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("outputs not idle in reset");

endmodule

bind lidar_polar_to_cartesian_core lp2c_checker u_lp2c_checker (.*);

// ===== test/lp2c_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lp2c_scoreboard
// watches the config port and both channels, predicts each coordinate word
// from the accepted sample and compares it with the word the core sends out
// ----------------------------------------------------------------------------
module lp2c_scoreboard
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [15:0]        raw_distance,
    input  logic [7:0]         intensity_in,
    input  logic [2:0]         echo_number,
    input  logic               last_of_scan,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [24:0] x_pos,
    input  logic signed [24:0] y_pos,
    input  logic signed [24:0] z_pos,
    input  logic [7:0]         intensity_out,
    input  logic [2:0]         echo_tag,
    input  logic               scan_end,
    output int                 errors,
    output int                 pending,
    output int                 points_seen
);

    typedef struct {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic signed [24:0] z;
        logic [7:0]         inten;
        logic [2:0]         echo;
        logic               last;
    } point_t;

    point_t point_q[$];

    longint m_start, m_step, m_scale, m_lcos, m_lsin;
    longint m_index;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp25(longint v);
        if (v > lp2c_pkg::OUT_MAX)
            return lp2c_pkg::OUT_MAX;
        if (v < lp2c_pkg::OUT_MIN)
            return lp2c_pkg::OUT_MIN;
        return v;
    endfunction

    function automatic longint arctan_unit(int i);
        longint t[24] = '{115200000, 68006531, 35932783, 18240042, 9155416, 4582171,
                          2291645, 1145892, 572955, 286479, 143239, 71620,
                          35810, 17905, 8952, 4476, 2238, 1119,
                          560, 280, 140, 70, 35, 17};
        return t[i];
    endfunction

    task automatic beam_trig(input longint ang, output longint c, output longint s);
        longint q, z, x, y, dx, dy;
        q = ang / lp2c_pkg::QUARTER_TURN;
        z = (ang - q * lp2c_pkg::QUARTER_TURN) * 256;
        x = lp2c_pkg::GAIN_Q30;
        y = 0;
        for (int i = 0; i < lp2c_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_unit(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_unit(i);
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_point();
        point_t p;
        longint dq, ang, c, s, t, nxt;
        dq = longint'(raw_distance) * m_scale;
        ang = (m_start + m_index * m_step - lp2c_pkg::QUARTER_TURN) % lp2c_pkg::FULL_TURN;
        if (ang < 0)
            ang += lp2c_pkg::FULL_TURN;
        beam_trig(ang, c, s);
        t = round_shift(dq * c, 30);
        p.x = 25'(clamp25(round_shift(t * m_lcos, 23)));
        t = round_shift(dq * s, 30);
        p.y = 25'(clamp25(round_shift(t * m_lcos, 23)));
        p.z = 25'(clamp25(round_shift(dq * m_lsin, 23)));
        p.inten = intensity_in;
        p.echo = echo_number;
        p.last = last_of_scan;
        point_q.push_back(p);
        nxt = (m_index + 1) & 13'h1fff;
        if (last_of_scan || nxt >= lp2c_pkg::MAX_POINTS)
            nxt = 0;
        m_index = nxt;
    endtask

    task automatic compare_point();
        point_t p;
        if (point_q.size() == 0)
        begin
            $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, x_pos, y_pos, z_pos);
            errors++;
            return;
        end
        p = point_q.pop_front();
        if (x_pos !== p.x || y_pos !== p.y || z_pos !== p.z || intensity_out !== p.inten
            || echo_tag !== p.echo || scan_end !== p.last)
        begin
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d i=%0d e=%0d l=%0d", $time,
                     p.x, p.y, p.z, p.inten, p.echo, p.last);
            $display("%0t:          got x=%0d y=%0d z=%0d i=%0d e=%0d l=%0d", $time,
                     x_pos, y_pos, z_pos, intensity_out, echo_tag, scan_end);
            errors++;
        end
        points_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_start = -450000;
            m_step = 5000;
            m_scale = 4096;
            m_lcos = 32767;
            m_lsin = 0;
            m_index = 0;
            errors = 0;
            points_seen = 0;
            point_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lp2c_pkg::CFG_FIRST_ANGLE:
                        m_start = longint'($signed(cfg_data));
                    lp2c_pkg::CFG_STEP_ANGLE:
                        m_step = longint'(cfg_data[16:0]);
                    lp2c_pkg::CFG_DISTANCE_SCALE:
                        m_scale = longint'(cfg_data[15:0]);
                    lp2c_pkg::CFG_LAYER_COSINE:
                        m_lcos = longint'($signed(cfg_data[15:0]));
                    lp2c_pkg::CFG_LAYER_SINE:
                        m_lsin = longint'($signed(cfg_data[15:0]));
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                compare_point();
            if (in_valid && !in_stall)
                predict_point();
        end
        pending = point_q.size();
    end

endmodule

// ===== test/tb_lidar_polar_to_cartesian_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_polar_to_cartesian_core
// drives range samples and register settings into the core with random
// gaps and output stalls; the checker predicts and compares every word
// ----------------------------------------------------------------------------
module tb_lidar_polar_to_cartesian_core;

    localparam int WATCHDOG = 20000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [22:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        raw_distance = '0;
    logic [7:0]         intensity_in = '0;
    logic [2:0]         echo_number = '0;
    logic               last_of_scan = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [24:0] x_pos, y_pos, z_pos;
    logic [7:0]         intensity_out;
    logic [2:0]         echo_tag;
    logic               scan_end;
    int                 errors, pending, points_seen;
    int                 idle_cycles = 0;
    bit                 busy_stretch = 1'b0;
    bit                 timed_out = 1'b0;
    int                 samples_sent = 0;
    int                 configs_done = 0;

    always #4 clk = ~clk;

    lidar_polar_to_cartesian_core uut (.*);

    lp2c_scoreboard checker_i (.*);

    // receiver stalls at random, except during the busy stretch
    always @(posedge clk)
        out_stall <= busy_stretch ? 1'b0 : ($urandom_range(99) < 34);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays up after an accepted word until the next word or an idle cycle
    task automatic send_sample(input logic [15:0] d, input logic [7:0] i,
                               input logic [2:0] e, input logic l);
        while (!busy_stretch && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_distance <= d;
        intensity_in <= i;
        echo_number <= e;
        last_of_scan <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input lp2c_pkg::cfg_index_t idx, input logic [22:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        configs_done++;
    endtask

    task automatic apply_setting(input int sa, input int st, input int sc,
                                 input int lc, input int ls);
        drain();
        write_reg(lp2c_pkg::CFG_FIRST_ANGLE, 23'(sa));
        write_reg(lp2c_pkg::CFG_STEP_ANGLE, 23'(st));
        write_reg(lp2c_pkg::CFG_DISTANCE_SCALE, 23'(sc));
        write_reg(lp2c_pkg::CFG_LAYER_COSINE, 23'(lc));
        write_reg(lp2c_pkg::CFG_LAYER_SINE, 23'(ls));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_samples(input int n);
        for (int k = 0; k < n; k++)
            send_sample(16'($urandom), 8'($urandom), 3'($urandom),
                        $urandom_range(99) < 3);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the sample fields at reset settings
        send_sample(16'h0000, 8'h00, 3'd0, 1'b0);
        send_sample(16'hffff, 8'hff, 3'd7, 1'b0);
        send_sample(16'h8000, 8'h55, 3'd5, 1'b1);
        send_sample(16'h7fff, 8'haa, 3'd2, 1'b0);
        // saturation with the largest scale and full layer terms
        apply_setting(3600000, 100000, 65535, -32768, -32768);
        for (int k = 0; k < 8; k++)
            send_sample(16'hffff, 8'(k), 3'(k), k == 7);
        apply_setting(-3600000, 100000, 65535, 32767, 32767);
        for (int k = 0; k < 6; k++)
            send_sample(16'hffff - 16'(k), 8'hf0, 3'd1, 1'b0);
        // zero step and scale, then a long run of words with no idling
        apply_setting(0, 0, 0, 0, 0);
        send_sample(16'h1234, 8'h01, 3'd3, 1'b0);
        apply_setting(123457, 1, 4096, 23170, 23170);
        busy_stretch = 1'b1;
        for (int k = 0; k < 200; k++)
            send_sample(16'($urandom_range(200, 60000)), 8'($urandom), 3'($urandom), 1'b0);
        busy_stretch = 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            apply_setting($urandom_range(7200000) - 3600000, $urandom_range(100000),
                          $urandom_range(65535), $urandom_range(65535) - 32768,
                          $urandom_range(65535) - 32768);
            if (ph == 3)
                busy_stretch = 1'b1;
            random_samples(160);
            busy_stretch = 1'b0;
        end
        drain();

        $display("sent %0d samples, checked %0d words, %0d register writes",
                 samples_sent, points_seen, configs_done);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
